// ----- src/dts_pkg.sv -----
// Package for the delayed trigger sequencer: sizes, codes and item types.
`default_nettype none
package dts_pkg;

  localparam int ENTRIES  = 16;
  localparam int MAX_FIRE = 16;
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int FIRE_W   = $clog2(MAX_FIRE + 1);
  localparam int SEC_IDX  = 1 % ENTRIES;
  localparam int TID_W    = 16;
  localparam int DLY_W    = 24;
  localparam int TIME_W   = 32;
  localparam int ACT_W    = 16;

  typedef enum logic [1:0] {
    FN_LOAD  = 2'd0,
    FN_START = 2'd1,
    FN_TICK  = 2'd2
  } func_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EVAL = 1'b1
  } state_t;

  typedef struct packed {
    logic [1:0]        func;
    logic [TID_W-1:0]  target_id;
    logic [DLY_W-1:0]  delay_ms;
    logic [TIME_W-1:0] now_ms;
    logic [ACT_W-1:0]  activator;
    logic              immediate;
  } in_t;

  typedef struct packed {
    logic [TID_W-1:0] fired_target;
    logic [ACT_W-1:0] fired_activator;
    logic             last_of_run;
    logic             finished;
  } out_t;

  typedef struct packed {
    logic [TID_W-1:0] tid;
    logic [DLY_W-1:0] dly;
  } entry_t;

  // load: sorted insert; rot: head moves to tail of the filled part
  typedef struct packed {
    logic load;
    logic rot;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ----- src/dts_cell.sv -----
// One table cell: holds an entry, takes part in sorted insert and rotation.
`default_nettype none
module dts_cell (
  input  wire logic               clk,
  input  wire dts_pkg::cell_ctl_t ctl,
  input  wire logic               valid,
  input  wire logic               tail,
  input  wire logic               b_prev,
  input  wire dts_pkg::entry_t    new_ent,
  input  wire dts_pkg::entry_t    prev_ent,
  input  wire dts_pkg::entry_t    next_ent,
  input  wire dts_pkg::entry_t    head_ent,
  output dts_pkg::entry_t         ent,
  output logic                    b
);
  import dts_pkg::*;

  entry_t ent_r, ent_nxt;

  // b: this cell sits at or after the insert position
  assign b   = !valid || (ent_r.dly > new_ent.dly);
  assign ent = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.load) begin
      if (b) begin
        ent_nxt = b_prev ? prev_ent : new_ent;
      end
    end else if (ctl.rot) begin
      if (tail) begin
        ent_nxt = head_ent;
      end else if (valid) begin
        ent_nxt = next_ent;
      end
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule
`default_nettype wire

// ----- src/dts_chain.sv -----
// Row of table cells with neighbor links, head and second-entry taps.
`default_nettype none
module dts_chain (
  input  wire logic                     clk,
  input  wire dts_pkg::cell_ctl_t       ctl,
  input  wire logic [dts_pkg::CNT_W-1:0] count,
  input  wire dts_pkg::entry_t          new_ent,
  output dts_pkg::entry_t               head,
  output logic [dts_pkg::DLY_W-1:0]     second_dly
);
  import dts_pkg::*;

  entry_t ents [ENTRIES];
  logic   bs   [ENTRIES];

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic   valid_i, tail_i, b_prev_i;
    entry_t prev_i, next_i;

    assign valid_i = CNT_W'(i) < count;
    assign tail_i  = CNT_W'(i + 1) == count;

    if (i == 0) begin : g_first
      assign b_prev_i = 1'b0;
      assign prev_i   = new_ent;
    end else begin : g_rest
      assign b_prev_i = bs[i-1];
      assign prev_i   = ents[i-1];
    end

    if (i == ENTRIES - 1) begin : g_last
      assign next_i = ents[0];
    end else begin : g_mid
      assign next_i = ents[i+1];
    end

    dts_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .valid    (valid_i),
      .tail     (tail_i),
      .b_prev   (b_prev_i),
      .new_ent  (new_ent),
      .prev_ent (prev_i),
      .next_ent (next_i),
      .head_ent (ents[0]),
      .ent      (ents[i]),
      .b        (bs[i])
    );
  end

  assign head       = ents[0];
  assign second_dly = ents[SEC_IDX].dly;

endmodule
`default_nettype wire

// ----- src/delayed_trigger_sequencer_core.sv -----
// Top level of the delayed trigger sequencer: run control and result register.
//
//  channel  ports                            dir  payload
//  input    in_valid / in_ready / in_data    in   dts_pkg::in_t
//  result   out_valid / out_ready / out_data out  dts_pkg::out_t
//
// A load item taken while no run is active and the table has room shifts the cell
// row in parallel to insert it. A start or tick item that evaluates is accepted,
// then fires one per cycle from the head cell, which rotates to the tail of the
// table, unless stalled, and ends with a closing check. Other items skip evaluation.
// Reset clears count, pointer and run state; the cell contents are undefined.
// A full result register stalls the fire sequence; no item is taken meanwhile.
`default_nettype none
module delayed_trigger_sequencer_core (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire dts_pkg::in_t   in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output dts_pkg::out_t       out_data
);
  import dts_pkg::*;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   next_r, next_nxt;
  logic [FIRE_W-1:0]  nfire_r, nfire_nxt;
  logic               running_r, running_nxt;
  logic [TIME_W-1:0]  start_r, start_nxt;
  logic [TIME_W-1:0]  elapsed_r, elapsed_nxt;
  logic [ACT_W-1:0]   act_r, act_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_r, out_nxt;

  cell_ctl_t          ctl;
  entry_t             new_ent, head;
  logic [DLY_W-1:0]   second_dly;
  logic               acc, due, fin, last;
  logic [CNT_W-1:0]   next_inc;

  assign in_ready  = state_r == ST_IDLE;
  assign acc       = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign new_ent.tid = in_data.target_id;
  assign new_ent.dly = in_data.delay_ms;

  dts_chain u_chain (
    .clk        (clk),
    .ctl        (ctl),
    .count      (count_r),
    .new_ent    (new_ent),
    .head       (head),
    .second_dly (second_dly)
  );

  assign next_inc = next_r + CNT_W'(1);
  assign due  = (next_r < count_r) && (TIME_W'(head.dly) <= elapsed_r) &&
                (nfire_r < FIRE_W'(MAX_FIRE));
  assign fin  = next_inc == count_r;
  assign last = fin || ((nfire_r + FIRE_W'(1)) == FIRE_W'(MAX_FIRE)) ||
                (TIME_W'(second_dly) > elapsed_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    next_nxt      = next_r;
    nfire_nxt     = nfire_r;
    running_nxt   = running_r;
    start_nxt     = start_r;
    elapsed_nxt   = elapsed_r;
    act_nxt       = act_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    ctl           = '0;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          case (in_data.func)
            FN_LOAD: begin
              if (!running_r && (count_r < CNT_W'(ENTRIES))) begin
                ctl.load  = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            FN_START: begin
              if (!running_r) begin
                running_nxt = 1'b1;
                act_nxt     = in_data.activator;
                start_nxt   = in_data.now_ms;
                next_nxt    = '0;
                elapsed_nxt = '0;
                nfire_nxt   = '0;
                if (in_data.immediate) begin
                  state_nxt = ST_EVAL;
                end
              end
            end
            FN_TICK: begin
              if (running_r) begin
                elapsed_nxt = in_data.now_ms - start_r;
                nfire_nxt   = '0;
                state_nxt   = ST_EVAL;
              end
            end
            default: ;
          endcase
        end
      end
      ST_EVAL: begin
        if (due) begin
          if (!out_valid_r || out_ready) begin
            ctl.rot                 = 1'b1;
            next_nxt                = next_inc;
            nfire_nxt               = nfire_r + FIRE_W'(1);
            out_valid_nxt           = 1'b1;
            out_nxt.fired_target    = head.tid;
            out_nxt.fired_activator = act_r;
            out_nxt.last_of_run     = last;
            out_nxt.finished        = fin;
          end
        end else begin
          state_nxt = ST_IDLE;
          if (next_r >= count_r) begin
            running_nxt = 1'b0;
            start_nxt   = '0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      next_r      <= '0;
      nfire_r     <= '0;
      running_r   <= 1'b0;
      start_r     <= '0;
      elapsed_r   <= '0;
      act_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      next_r      <= next_nxt;
      nfire_r     <= nfire_nxt;
      running_r   <= running_nxt;
      start_r     <= start_nxt;
      elapsed_r   <= elapsed_nxt;
      act_r       <= act_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule
`default_nettype wire

// ----- tb/sv/delayed_trigger_sequencer_checker.sv -----
`timescale 1ns / 100ps
// Checker for the delayed trigger sequencer: mirrors the entry table and checks every fire.
module delayed_trigger_sequencer_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_ready,
  input  dts_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  dts_pkg::out_t out_data,
  output int            fail_count,
  output int            pending
);
  import dts_pkg::*;

  logic [TID_W-1:0]  tbl_tid [ENTRIES];
  logic [DLY_W-1:0]  tbl_dly [ENTRIES];
  int                tbl_count;
  int                fire_ptr;
  logic              run_on;
  logic [TIME_W-1:0] run_start;
  logic [ACT_W-1:0]  run_act;
  out_t              fire_q[$];
  int                fails;

  task automatic sorted_insert(input logic [TID_W-1:0] tid, input logic [DLY_W-1:0] dly);
    int pos;
    if (run_on || tbl_count >= ENTRIES) return;
    pos = tbl_count;
    while (pos > 0 && tbl_dly[pos-1] > dly) pos--;
    for (int k = tbl_count; k > pos; k--) begin
      tbl_tid[k] = tbl_tid[k-1];
      tbl_dly[k] = tbl_dly[k-1];
    end
    tbl_tid[pos] = tid;
    tbl_dly[pos] = dly;
    tbl_count++;
  endtask

  task automatic fire_due(input logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] elapsed;
    int n;
    logic done;
    out_t r;
    elapsed = now - run_start;
    n = 0;
    while (n < MAX_FIRE && fire_ptr < tbl_count && tbl_dly[fire_ptr] <= elapsed) begin
      r.fired_target    = tbl_tid[fire_ptr];
      r.fired_activator = run_act;
      fire_ptr++;
      done = (fire_ptr >= tbl_count);
      r.finished    = done;
      r.last_of_run = done || (n + 1 == MAX_FIRE) || (tbl_dly[fire_ptr] > elapsed);
      fire_q.push_back(r);
      n++;
    end
    if (fire_ptr >= tbl_count) begin
      run_on    = 1'b0;
      run_start = '0;
    end
  endtask

  task automatic apply_item(input in_t it);
    case (it.func)
      FN_LOAD: sorted_insert(it.target_id, it.delay_ms);
      FN_START: begin
        if (!run_on) begin
          run_on    = 1'b1;
          run_act   = it.activator;
          run_start = it.now_ms;
          fire_ptr  = 0;
          if (it.immediate) fire_due(it.now_ms);
        end
      end
      FN_TICK: begin
        if (run_on) fire_due(it.now_ms);
      end
      default: ;
    endcase
  endtask

  task automatic cmp_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      fails++;
    end
  endtask

  task automatic check_fire(input out_t got);
    out_t want;
    if (fire_q.size() == 0) begin
      $error("result item with none expected: %h", got);
      fails++;
    end else begin
      want = fire_q.pop_front();
      cmp_field("fired_target", want.fired_target, got.fired_target);
      cmp_field("fired_activator", want.fired_activator, got.fired_activator);
      cmp_field("last_of_run", 16'(want.last_of_run), 16'(got.last_of_run));
      cmp_field("finished", 16'(want.finished), 16'(got.finished));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      tbl_count = 0;
      fire_ptr  = 0;
      run_on    = 1'b0;
      run_start = '0;
      run_act   = '0;
      fire_q.delete();
    end else begin
      // results leave before a new item can add to the queue
      if (out_valid && out_ready) check_fire(out_data);
      if (in_valid && in_ready) apply_item(in_data);
    end
    fail_count <= fails;
    pending    <= fire_q.size();
  end

endmodule

// ----- tb/sv/delayed_trigger_sequencer_core_test.sv -----
`timescale 1ns / 100ps
// Testbench top for the delayed trigger sequencer: clock, reset, stimulus and verdict.
module delayed_trigger_sequencer_core_test;
  import dts_pkg::*;

  localparam logic [1:0] FN_SPARE = 2'd3;
  localparam int RANDOM_ITEMS = 110;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_t               in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_t              out_data;
  logic              calm = 1'b0;
  int                rx_wait = 1;
  int                fail_count;
  int                pending;
  logic [TIME_W-1:0] run_t0;
  int                items_sent = 0;

  always #1 clk = ~clk;

  delayed_trigger_sequencer_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  delayed_trigger_sequencer_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // result side: after each item, ready may drop low for a random wait, never when calm
  always @(posedge clk) begin
    if (out_ready) begin
      if (out_valid) begin
        rx_wait = calm ? 0 : $urandom_range(0, 6);
        if (rx_wait != 0) out_ready <= 1'b0;
      end
    end else begin
      rx_wait--;
      if (rx_wait <= 0) out_ready <= 1'b1;
    end
  end

  task automatic send(input in_t it);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  function automatic in_t load_item(input logic [TID_W-1:0] tid, input logic [DLY_W-1:0] dly);
    in_t it;
    it = '0;
    it.func      = FN_LOAD;
    it.target_id = tid;
    it.delay_ms  = dly;
    return it;
  endfunction

  function automatic in_t start_item(input logic [TIME_W-1:0] now, input logic [ACT_W-1:0] act,
                                     input logic imm);
    in_t it;
    it = '0;
    it.func      = FN_START;
    it.now_ms    = now;
    it.activator = act;
    it.immediate = imm;
    return it;
  endfunction

  function automatic in_t tick_item(input logic [TIME_W-1:0] now);
    in_t it;
    it = '0;
    it.func   = FN_TICK;
    it.now_ms = now;
    return it;
  endfunction

  function automatic in_t spare_item();
    in_t it;
    it.func      = FN_SPARE;
    it.target_id = 16'($urandom);
    it.delay_ms  = 24'($urandom);
    it.now_ms    = $urandom;
    it.activator = 16'($urandom);
    it.immediate = 1'($urandom);
    return it;
  endfunction

  initial begin
    #1_000_000;
    $display("delayed_trigger_sequencer_core regression: fail");
    $finish;
  end

  initial begin
    logic [TIME_W-1:0] t;
    int seq;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, idle tick, unused code
    send(start_item(32'h0000_0000, 16'hFFFF, 1'b1));
    send(tick_item(32'hFFFF_FFFF));
    send(spare_item());
    // extremes and equal delays
    send(load_item(16'hFFFF, 24'hFF_FFFF));
    send(load_item(16'h0000, 24'h00_0000));
    send(load_item(16'h1234, 24'd5));
    send(load_item(16'h1235, 24'd5));
    send(load_item(16'hABCD, 24'd3));
    // run across the 32-bit wrap; load and start during a run are dropped
    send(start_item(32'hFFFF_FFF0, 16'h0000, 1'b1));
    send(load_item(16'h5555, 24'd1));
    send(start_item(32'h0000_0000, 16'h7777, 1'b0));
    send(tick_item(32'hFFFF_FFF2));
    send(tick_item(32'h0000_0000));
    send(tick_item(32'h00FF_FFEE));
    send(tick_item(32'h00FF_FFEF));
    // whole table due in one tick
    send(start_item(32'd100, 16'h5A5A, 1'b0));
    send(tick_item(32'd99));

    seq = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (seq % 4 == 0) calm <= ($urandom_range(0, 3) == 0);
      seq++;
      repeat ($urandom_range(0, 2)) begin
        send(load_item(16'($urandom), ($urandom_range(0, 3) == 0) ?
                       24'($urandom) : 24'($urandom_range(0, 400))));
      end
      run_t0 = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF00 + $urandom_range(0, 255) : $urandom;
      send(start_item(run_t0, 16'($urandom), 1'($urandom)));
      t = run_t0;
      repeat ($urandom_range(1, 5)) begin
        case ($urandom_range(0, 7))
          0: send(load_item(16'($urandom), 24'($urandom)));
          1: send(start_item(run_t0, 16'($urandom), 1'($urandom)));
          2: send(spare_item());
          default: ;
        endcase
        t += $urandom_range(0, 150);
        send(tick_item(t));
      end
      // far enough past any delay to close the run
      send(tick_item(run_t0 + 32'h0100_0000 + $urandom_range(0, 4095)));
    end
    in_valid <= 1'b0;

    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("delayed_trigger_sequencer_core regression: pass");
    end else begin
      $display("delayed_trigger_sequencer_core regression: fail");
    end
    $finish;
  end

endmodule
